FILE: src/cave_automaton_generation_unit_macros.svh
// ----------------------------------------------------------------------------
// Cave automaton assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef CAVE_AUTOMATON_GENERATION_UNIT_MACROS_SVH
`define CAVE_AUTOMATON_GENERATION_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define CAGU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// cond must never be true outside reset
`define CAGU_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CAGU_ASSERT(label, clk, rst_n, prop, msg)
`define CAGU_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

FILE: src/cagu_pkg.sv
// ----------------------------------------------------------------------------
// Cave automaton package
// Grid geometry, payload types and the wall decision rule.
// ----------------------------------------------------------------------------
package cagu_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;

  localparam int COL_W = $clog2(GRID_WIDTH);
  localparam int ROW_W = $clog2(GRID_HEIGHT + 1);

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_FILL = ROW_W'(GRID_HEIGHT);

  localparam int THR_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int POS_W      = 6;

  localparam logic [CFG_IDX_W-1:0] REG_KEEP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BIRTH = 1'b1;

  localparam logic [THR_W-1:0] KEEP_RESET  = 4'd4;
  localparam logic [THR_W-1:0] BIRTH_RESET = 4'd5;

  typedef struct packed {
    logic cell_wall;
  } in_data_t;

  typedef struct packed {
    logic             next_wall;
    logic [POS_W-1:0] out_col;
    logic [POS_W-1:0] out_row;
    logic             run_last;
    logic             frame_last;
  } out_data_t;

  // Count wall neighbours around the center bit and apply the keep/birth rule
  function automatic logic decide(input logic [8:0] w, input logic [THR_W-1:0] keep,
                                  input logic [THR_W-1:0] birth);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) n = n + 4'(w[i]);
    end
    return w[4] ? (n >= keep) : (n >= birth);
  endfunction

endpackage

FILE: src/cagu_in_if.sv
// ----------------------------------------------------------------------------
// Cave automaton input channel
// Valid/ready channel carrying one grid cell per request.
// ----------------------------------------------------------------------------
interface cagu_in_if;
  logic               valid;
  logic               ready;
  cagu_pkg::in_data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/cagu_out_if.sv
// ----------------------------------------------------------------------------
// Cave automaton result channel
// Valid/ready channel carrying one next-generation cell per request.
// ----------------------------------------------------------------------------
interface cagu_out_if;
  logic                valid;
  logic                ready;
  cagu_pkg::out_data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/cave_automaton_generation_unit.sv
// Output: a result is loaded into the output register in the cycle after the request that completes it.
// Throughput: one cell per cycle while the output is ready; the last cell of each row after the first
//   yields two results and holds off the input while the second result drains from the pending register.
// Reset (rst_n low, synchronous): counters, window, valid flags cleared; thresholds 4 and 5.
// Line shift registers are not reset; their contents are masked until rewritten.
// ----------------------------------------------------------------------------
// Cave automaton generation unit
// One generation of the 4-5 cave automaton over a raster stream, using two
// row shift lines and a 3x3 window, emitting one row and one column behind.
// ----------------------------------------------------------------------------
`include "cave_automaton_generation_unit_macros.svh"

module cave_automaton_generation_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  cagu_in_if.sink                             in_ch,
  cagu_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [cagu_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [cagu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int W = cagu_pkg::GRID_WIDTH;

  logic [cagu_pkg::THR_W-1:0] keep_thr_r, birth_thr_r;
  logic [cagu_pkg::COL_W-1:0] col_r, col_nxt;
  logic [cagu_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [8:0]                 win_r, win_nxt;
  logic [W-1:0]               upper_line_r, middle_line_r;

  cagu_pkg::out_data_t        out_r, out_nxt, pend_r, pend_nxt;
  logic                       out_v_r, out_v_nxt, pend_v_r, pend_v_nxt;

  logic                       in_ready, in_acc, out_take;
  logic                       bit_in, up_bit, mid_bit, emit, row_end;
  logic [8:0]                 win_base, win_a, win_b;
  cagu_pkg::out_data_t        res_a, res_b;

  assign in_ready     = ~pend_v_r & (~out_v_r | out_ch.ready);
  assign in_ch.ready  = in_ready;
  assign in_acc       = in_ch.valid & in_ready;
  assign out_take     = out_v_r & out_ch.ready;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  // Column taps: the oldest bit of each line is the same column one row earlier
  assign bit_in  = (row_r == cagu_pkg::ROW_FILL) ? 1'b0 : in_ch.data.cell_wall;
  assign up_bit  = (row_r == cagu_pkg::ROW_W'(1)) ? 1'b0 : upper_line_r[W-1];
  assign mid_bit = middle_line_r[W-1];

  assign emit    = (row_r != '0) && (col_r != '0);
  assign row_end = (col_r == cagu_pkg::COL_LAST);

  assign win_base = (col_r == '0) ? 9'd0 : win_r;
  assign win_a    = {win_base[5:0], bit_in, mid_bit, up_bit};
  assign win_b    = {win_a[5:0], 3'b000};

  always_comb begin
    res_a.next_wall  = cagu_pkg::decide(win_a, keep_thr_r, birth_thr_r);
    res_a.out_col    = cagu_pkg::POS_W'(col_r - cagu_pkg::COL_W'(1));
    res_a.out_row    = cagu_pkg::POS_W'(row_r - cagu_pkg::ROW_W'(1));
    res_a.run_last   = ~row_end;
    res_a.frame_last = 1'b0;

    res_b.next_wall  = cagu_pkg::decide(win_b, keep_thr_r, birth_thr_r);
    res_b.out_col    = cagu_pkg::POS_W'(col_r);
    res_b.out_row    = cagu_pkg::POS_W'(row_r - cagu_pkg::ROW_W'(1));
    res_b.run_last   = 1'b1;
    res_b.frame_last = (row_r == cagu_pkg::ROW_FILL);
  end

  always_comb begin
    win_nxt = win_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      win_nxt = (emit && row_end) ? win_b : win_a;
      if (row_end) begin
        col_nxt = '0;
        row_nxt = (row_r == cagu_pkg::ROW_FILL) ? '0 : row_r + cagu_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + cagu_pkg::COL_W'(1);
      end
    end
  end

  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    if (out_take) begin
      out_v_nxt  = pend_v_r;
      out_nxt    = pend_r;
      pend_v_nxt = 1'b0;
    end
    if (in_acc && emit) begin
      out_v_nxt = 1'b1;
      out_nxt   = res_a;
      if (row_end) begin
        pend_v_nxt = 1'b1;
        pend_nxt   = res_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_thr_r  <= cagu_pkg::KEEP_RESET;
      birth_thr_r <= cagu_pkg::BIRTH_RESET;
      col_r       <= '0;
      row_r       <= '0;
      win_r       <= '0;
      out_v_r     <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == cagu_pkg::REG_KEEP) begin
        keep_thr_r <= cfg_wdata[cagu_pkg::THR_W-1:0];
      end
      if (cfg_we && cfg_idx == cagu_pkg::REG_BIRTH) begin
        birth_thr_r <= cfg_wdata[cagu_pkg::THR_W-1:0];
      end
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      win_r    <= win_nxt;
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  // Payload: result registers and row shift lines
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
    if (in_acc) begin
      upper_line_r  <= {upper_line_r[W-2:0], mid_bit};
      middle_line_r <= {middle_line_r[W-2:0], bit_in};
    end
  end

  `CAGU_ASSERT(a_pend_behind_out, clk, rst_n, pend_v_r |-> out_v_r, "pending result without output result")
  `CAGU_ASSERT(a_pend_run_last, clk, rst_n, pend_v_r |-> pend_r.run_last, "pending result must close its run")
  `CAGU_ASSERT(a_row_end_emits, clk, rst_n, (in_acc && emit && row_end) |=> (out_v_r && pend_v_r), "row end did not produce two results")
  `CAGU_ASSERT(a_frame_last_closes, clk, rst_n, (out_v_r && out_r.frame_last) |-> out_r.run_last, "frame end not last of run")
  `CAGU_ASSERT_NEVER(a_row_range, clk, rst_n, row_r > cagu_pkg::ROW_FILL, "row counter beyond filler row")

endmodule
